@@ rtl/core/bhgs_pkg.sv @@
`default_nettype none
package bhgs_pkg;

  localparam int MAX_GRID  = 128;
  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 17;
  localparam int HEIGHT_W  = 16;
  localparam int CFG_W     = 8;
  localparam int CFG_RESET = 128;

  // Integer part of a coordinate, cell index within the grid, and the grid
  // split into four banks by the parity of x and z.
  localparam int INT_W      = COORD_W - FRAC_BITS;
  localparam int CELL_W     = $clog2(MAX_GRID);
  localparam int HALF_W     = CELL_W - 1;
  localparam int BANK_AW    = 2 * HALF_W;
  localparam int BANK_DEPTH = (MAX_GRID * MAX_GRID) / 4;
  localparam int N_BANKS    = 4;
  localparam int SIZE_W     = $clog2(MAX_GRID + 1);
  localparam int CMP_W      = ((INT_W > SIZE_W) ? INT_W : SIZE_W) + 1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                       command;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_z;
    logic signed [HEIGHT_W-1:0] height_value;
  } req_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] h00;
    logic signed [HEIGHT_W-1:0] h10;
    logic signed [HEIGHT_W-1:0] h01;
    logic signed [HEIGHT_W-1:0] h11;
    logic [FRAC_BITS-1:0]       tx;
    logic [FRAC_BITS-1:0]       tz;
  } corners_t;

endpackage
`default_nettype wire

@@ rtl/core/bhgs_ifs.sv @@
`default_nettype none
interface bhgs_in_if import bhgs_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_z;
  logic signed [HEIGHT_W-1:0] height_value;

  modport source (output valid, command, coord_x, coord_z, height_value, input ready);
  modport sink   (input valid, command, coord_x, coord_z, height_value, output ready);
endinterface

interface bhgs_out_if import bhgs_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height_out;

  modport source (output valid, height_out, input ready);
  modport sink   (input valid, height_out, output ready);
endinterface

interface bhgs_cfg_if import bhgs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] grid_size;

  modport source (output valid, grid_size, input ready);
  modport sink   (input valid, grid_size, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bhgs_ram.sv @@
`default_nettype none
module bhgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rd_r <= mem_r[addr];
    end
  end

  assign rdata = rd_r;

endmodule
`default_nettype wire

@@ rtl/core/bhgs_store.sv @@
`default_nettype none
module bhgs_store import bhgs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              issue,
  input  wire req_t              req,
  input  wire logic [SIZE_W-1:0] size_use,
  output corners_t               corners
);

  // The four corners of a cell always fall in four different parity banks,
  // so one query reads each bank exactly once.

  function automatic logic in_rng(input logic signed [INT_W:0] c,
                                  input logic [SIZE_W-1:0] n);
    return !c[INT_W] && (CMP_W'(c[INT_W-1:0]) < CMP_W'(n));
  endfunction

  logic signed [INT_W:0] xa, xb, za, zb;
  logic                  is_query, is_load;

  logic signed [INT_W:0]      bank_x [N_BANKS];
  logic signed [INT_W:0]      bank_z [N_BANKS];
  logic                       bank_ok [N_BANKS];
  logic [BANK_AW-1:0]         bank_addr [N_BANKS];
  logic                       bank_we [N_BANKS];
  logic [HEIGHT_W-1:0]        bank_rd [N_BANKS];
  logic signed [HEIGHT_W-1:0] masked [N_BANKS];

  logic [N_BANKS-1:0]   ok_r;
  logic                 px_r, pz_r;
  logic [FRAC_BITS-1:0] tx_r, tz_r;

  assign xa       = {req.coord_x[COORD_W-1], req.coord_x[COORD_W-1:FRAC_BITS]};
  assign za       = {req.coord_z[COORD_W-1], req.coord_z[COORD_W-1:FRAC_BITS]};
  assign xb       = xa + (INT_W+1)'(1);
  assign zb       = za + (INT_W+1)'(1);
  assign is_query = issue && (req.command == CMD_QUERY);
  assign is_load  = issue && (req.command == CMD_LOAD);

  for (genvar b = 0; b < N_BANKS; b++) begin : g_bank
    localparam logic PX = ((b % 2) == 1);
    localparam logic PZ = ((b / 2) == 1);

    assign bank_x[b]    = (xa[0] == PX) ? xa : xb;
    assign bank_z[b]    = (za[0] == PZ) ? za : zb;
    assign bank_ok[b]   = in_rng(bank_x[b], size_use) && in_rng(bank_z[b], size_use);
    assign bank_addr[b] = {bank_z[b][CELL_W-1:1], bank_x[b][CELL_W-1:1]};
    // A load hits only the bank of its own parity, where the address is its cell.
    assign bank_we[b]   = is_load && bank_ok[b] && (xa[0] == PX) && (za[0] == PZ);

    bhgs_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .re    (is_query),
      .addr  (bank_addr[b]),
      .wdata (req.height_value),
      .rdata (bank_rd[b])
    );

    assign masked[b] = ok_r[b] ? $signed(bank_rd[b]) : '0;
  end

  always_ff @(posedge clk) begin
    if (is_query) begin
      ok_r <= {bank_ok[3], bank_ok[2], bank_ok[1], bank_ok[0]};
      px_r <= xa[0];
      pz_r <= za[0];
      tx_r <= req.coord_x[FRAC_BITS-1:0];
      tz_r <= req.coord_z[FRAC_BITS-1:0];
    end
  end

  always_comb begin
    corners.h00 = masked[{pz_r, px_r}];
    corners.h10 = masked[{pz_r, ~px_r}];
    corners.h01 = masked[{~pz_r, px_r}];
    corners.h11 = masked[{~pz_r, ~px_r}];
    corners.tx  = tx_r;
    corners.tz  = tz_r;
  end

endmodule
`default_nettype wire

@@ rtl/core/bhgs_interp.sv @@
`default_nettype none
module bhgs_interp import bhgs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                query_issue,
  input  wire corners_t            corners,
  input  wire logic                out_ready,
  output logic                     issue_ready,
  output logic                     out_valid,
  output logic signed [HEIGHT_W-1:0] height_out
);

  localparam int PROD_W = HEIGHT_W + FRAC_BITS + 2;

  // a + floor((b - a) * t / 2^FRAC_BITS). The true result lies between a and
  // b, so the low bits of the sum are all that is needed.
  function automatic logic signed [HEIGHT_W-1:0] lerp(input logic signed [HEIGHT_W-1:0] a,
                                                      input logic signed [HEIGHT_W-1:0] b,
                                                      input logic [FRAC_BITS-1:0] t);
    logic signed [PROD_W-1:0] d;
    logic signed [PROD_W-1:0] tt;
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] s;
    d  = PROD_W'(b) - PROD_W'(a);
    tt = $signed(PROD_W'(t));
    p  = d * tt;
    s  = p >>> FRAC_BITS;
    return a + s[HEIGHT_W-1:0];
  endfunction

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  logic signed [HEIGHT_W-1:0] h0_r, h1_r, out_r;
  logic [FRAC_BITS-1:0]       tz_r;

  // Each stage advances when the stage after it is free or moving.
  assign en3 = !v3_r || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= query_issue;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      h0_r <= lerp(corners.h00, corners.h10, corners.tx);
      h1_r <= lerp(corners.h01, corners.h11, corners.tx);
      tz_r <= corners.tz;
    end
    if (en3 && v2_r) begin
      out_r <= lerp(h0_r, h1_r, tz_r);
    end
  end

  assign issue_ready = en1;
  assign out_valid   = v3_r;
  assign height_out  = out_r;

endmodule
`default_nettype wire

@@ rtl/core/bilinear_height_grid_sampler.sv @@
`default_nettype none
// Bilinear height grid sampler. Takes one word per clock, load or query, while
// the input is not held back by a stalled output, and returns each query's
// interpolated Q8.8 height through the registered bank read, the registers of
// the blend along x and the register of the blend along z; loads give no word.
// The rate of one word per cycle is set by the height store, split into four
// single-port banks by the parity of x and z so that the four corners of a
// cell are read in the same cycle, one from each bank. A load followed directly
// by a query of the same cell is seen, since the write lands before the next
// read. The store is not cleared at reset: every cell must be loaded before it
// is queried. The grid size register may only be written while no query is in flight.
module bilinear_height_grid_sampler import bhgs_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  bhgs_in_if.sink    in_ch,
  bhgs_out_if.source out_ch,
  bhgs_cfg_if.sink   cfg_ch
);

  logic [CFG_W-1:0]  grid_size_r;
  logic [SIZE_W-1:0] size_use;
  logic              issue_ready;
  logic              issue;
  req_t              req;
  corners_t          corners;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= CFG_W'(CFG_RESET);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      grid_size_r <= cfg_ch.grid_size;
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign size_use = (int'(grid_size_r) > MAX_GRID) ? SIZE_W'(MAX_GRID)
                                                   : SIZE_W'(grid_size_r);

  assign req.command      = in_ch.command;
  assign req.coord_x      = in_ch.coord_x;
  assign req.coord_z      = in_ch.coord_z;
  assign req.height_value = in_ch.height_value;

  assign in_ch.ready = issue_ready;
  assign issue       = in_ch.valid && issue_ready;

  bhgs_store u_store (
    .clk      (clk),
    .issue    (issue),
    .req      (req),
    .size_use (size_use),
    .corners  (corners)
  );

  bhgs_interp u_interp (
    .clk         (clk),
    .rst_n       (rst_n),
    .query_issue (issue && (in_ch.command == CMD_QUERY)),
    .corners     (corners),
    .out_ready   (out_ch.ready),
    .issue_ready (issue_ready),
    .out_valid   (out_ch.valid),
    .height_out  (out_ch.height_out)
  );

endmodule
`default_nettype wire

@@ rtl/core/bhgs_checker.sv @@
`default_nettype none
module bhgs_checker import bhgs_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_command,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [HEIGHT_W-1:0] height_out
);

  // Nothing comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present straight after reset");

  // The input is held back only when the whole pipeline is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled output");

  // An accepted query reaches the output when out_ready stays high while it passes through.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == CMD_QUERY)) ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("query result late");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(height_out)))
    else $error("stalled result word changed or dropped");

endmodule

bind bilinear_height_grid_sampler bhgs_checker u_bhgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .height_out (out_ch.height_out)
);
`default_nettype wire

@@ verif/bilinear_height_grid_sampler_tb.sv @@
module bilinear_height_grid_sampler_tb;
  import bhgs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int GRID_CELLS  = MAX_GRID * MAX_GRID;
  localparam int SETTLE      = 8;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  bhgs_in_if  in_ch();
  bhgs_out_if out_ch();
  bhgs_cfg_if cfg_ch();

  bilinear_height_grid_sampler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // Predictor state, updated as words are accepted by the block.
  logic signed [HEIGHT_W-1:0] height_grid [GRID_CELLS];
  logic [CFG_W-1:0]           grid_cfg = CFG_W'(CFG_RESET);
  logic signed [HEIGHT_W-1:0] expected_heights [$];

  // Generator state, updated as words are queued, so that no query ever
  // touches an in-grid cell that has not been loaded.
  bit   cell_written [GRID_CELLS];
  int   gen_size;
  req_t pending_words [$];
  int   n_queued = 0;
  int   n_taken  = 0;

  int          err_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_count = 0;
  stall_mode_e stall_mode = STALL_NONE;
  req_t        next_word;
  req_t        seen_word;

  function automatic int size_limit(int v);
    return (v > MAX_GRID) ? MAX_GRID : v;
  endfunction

  function automatic bit on_grid(int x, int z, int n);
    return x >= 0 && x < n && z >= 0 && z < n;
  endfunction

  function automatic int corner_height(int x, int z);
    int h;
    h = 0;
    if (on_grid(x, z, size_limit(grid_cfg)))
      h = height_grid[z * MAX_GRID + x];
    return h;
  endfunction

  function automatic int blend(int a, int b, int t);
    return a + ((b - a) * t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] interp_height(req_t w);
    int x0, z0, tx, tz, h0, h1, r;
    x0 = $signed(w.coord_x);
    z0 = $signed(w.coord_z);
    x0 = x0 >>> FRAC_BITS;
    z0 = z0 >>> FRAC_BITS;
    tx = w.coord_x[FRAC_BITS-1:0];
    tz = w.coord_z[FRAC_BITS-1:0];
    h0 = blend(corner_height(x0, z0), corner_height(x0 + 1, z0), tx);
    h1 = blend(corner_height(x0, z0 + 1), corner_height(x0 + 1, z0 + 1), tx);
    r  = blend(h0, h1, tz);
    return r[HEIGHT_W-1:0];
  endfunction

  task automatic take_word(req_t w);
    int x0, z0;
    x0 = $signed(w.coord_x);
    z0 = $signed(w.coord_z);
    x0 = x0 >>> FRAC_BITS;
    z0 = z0 >>> FRAC_BITS;
    if (w.command == CMD_LOAD) begin
      if (on_grid(x0, z0, size_limit(grid_cfg)))
        height_grid[z0 * MAX_GRID + x0] = w.height_value;
    end else begin
      expected_heights = {expected_heights, interp_height(w)};
    end
  endtask

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 10)
      $display("%s", msg);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen_word.command      = in_ch.command;
        seen_word.coord_x      = in_ch.coord_x;
        seen_word.coord_z      = in_ch.coord_z;
        seen_word.height_value = in_ch.height_value;
        take_word(seen_word);
        n_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.command      <= next_word.command;
          in_ch.coord_x      <= next_word.coord_x;
          in_ch.coord_z      <= next_word.coord_z;
          in_ch.height_value <= next_word.height_value;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word and stalls on a changing pattern.
  always @(posedge clk) begin
    logic signed [HEIGHT_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_heights.size() == 0) begin
        flag_error($sformatf("unexpected result word: height_out %0d",
                             $signed(out_ch.height_out)));
      end else begin
        want = expected_heights.pop_front();
        if (out_ch.height_out !== want)
          flag_error($sformatf("height_out mismatch: expected %0d, got %0d",
                               $signed(want), $signed(out_ch.height_out)));
      end
    end
    stall_count <= stall_count + 1;
    if (stall_count % 97 == 0)
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_ch.ready <= 1'b1;
      STALL_HALF:  out_ch.ready <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:     out_ch.ready <= (stall_count % 7) < 4;
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_frac();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return (1 << FRAC_BITS) - 1;
    return $urandom_range(0, (1 << FRAC_BITS) - 1);
  endfunction

  function automatic int pick_height();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32767;
    if (r == 1) return -32768;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  function automatic int pick_coord();
    return $urandom_range(0, 131071) - 65536;
  endfunction

  function automatic bit corner_loaded(int x, int z);
    if (!on_grid(x, z, gen_size))
      return 1'b1;
    return cell_written[z * MAX_GRID + x];
  endfunction

  function automatic bit query_safe(int cx, int cz);
    int x0, z0;
    x0 = cx >>> FRAC_BITS;
    z0 = cz >>> FRAC_BITS;
    return corner_loaded(x0, z0) && corner_loaded(x0 + 1, z0) &&
           corner_loaded(x0, z0 + 1) && corner_loaded(x0 + 1, z0 + 1);
  endfunction

  task automatic add_item(logic cmd, int cx, int cz, int h);
    req_t w;
    int   x0, z0;
    w.command      = cmd;
    w.coord_x      = cx[COORD_W-1:0];
    w.coord_z      = cz[COORD_W-1:0];
    w.height_value = h[HEIGHT_W-1:0];
    x0 = cx >>> FRAC_BITS;
    z0 = cz >>> FRAC_BITS;
    if (cmd == CMD_LOAD && on_grid(x0, z0, gen_size))
      cell_written[z0 * MAX_GRID + x0] = 1'b1;
    pending_words = {pending_words, w};
    n_queued++;
  endtask

  task automatic add_load(int x, int z);
    add_item(CMD_LOAD, x * 256 + $urandom_range(0, 255), z * 256 + $urandom_range(0, 255),
             pick_height());
  endtask

  task automatic add_random_query(int px, int pz, int pw, int ph);
    int cx, cz, x0, tries;
    bit found;
    found = 1'b0;
    for (tries = 0; tries < 12 && !found; tries++) begin
      case ($urandom_range(0, 9))
        0: begin
          cx = pick_coord();
          cz = pick_coord();
        end
        1: begin
          cx = ($urandom_range(0, 2) - 1) * 256 + pick_frac();
          cz = ($urandom_range(0, 2) - 1) * 256 + pick_frac();
        end
        2, 3: begin
          case ($urandom_range(0, 4))
            0:       x0 = -1;
            1:       x0 = gen_size - 1;
            2:       x0 = gen_size;
            3:       x0 = -256;
            default: x0 = 255;
          endcase
          cx = x0 * 256 + pick_frac();
          cz = (pz - 1 + $urandom_range(0, ph)) * 256 + pick_frac();
          if ($urandom_range(0, 1)) begin
            x0 = cx;
            cx = cz;
            cz = x0;
          end
        end
        default: begin
          cx = (px - 1 + $urandom_range(0, pw)) * 256 + pick_frac();
          cz = (pz - 1 + $urandom_range(0, ph)) * 256 + pick_frac();
        end
      endcase
      found = query_safe(cx, cz);
    end
    // Two cells left of the grid: every corner lies outside it.
    if (!found) begin
      cx = -2 * 256 + pick_frac();
      cz = pick_coord();
    end
    add_item(CMD_QUERY, cx, cz, pick_height());
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || expected_heights.size() != 0)
      @(posedge clk);
    // A trailing load gives no word back, so let the pipeline empty as well.
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_grid_size(int v);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.grid_size <= v[CFG_W-1:0];
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    grid_cfg     = v[CFG_W-1:0];
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_directed();
    add_item(CMD_LOAD, 'h0FF, 0, 32767);
    add_item(CMD_LOAD, 256 + 'h80, 'h7F, -32768);
    add_item(CMD_LOAD, 0, 256 + 'h01, -32768);
    add_item(CMD_LOAD, 511, 511, 32767);
    // Loads that fall outside the grid must leave the store alone.
    add_item(CMD_LOAD, 512, 0, 1234);
    add_item(CMD_LOAD, -1, 0, 1234);
    add_item(CMD_LOAD, 0, 517, -1234);
    add_item(CMD_LOAD, -65536, 65535, 777);
    add_item(CMD_QUERY, 0, 0, 0);
    add_item(CMD_QUERY, 255, 255, 0);
    add_item(CMD_QUERY, 128, 0, 0);
    add_item(CMD_QUERY, 0, 255, 0);
    add_item(CMD_QUERY, 384, 384, -1);
    add_item(CMD_QUERY, -1, -1, 0);
    add_item(CMD_QUERY, -256, 200, 0);
    add_item(CMD_QUERY, 65535, 65535, 0);
    add_item(CMD_QUERY, -65536, -65536, 0);
    add_item(CMD_QUERY, 100, -65536, 0);
    // A query straight after a load of the same cell must see the new height.
    add_item(CMD_LOAD, 0, 0, -5);
    add_item(CMD_QUERY, 0, 0, 0);
    add_item(CMD_QUERY, 200, 50, 0);
  endtask

  task automatic run_phase(int size_val, int n_random, bit with_directed);
    int px, pz, pw, ph, i, j, r, span;
    wait_drained();
    write_grid_size(size_val);
    gen_size = size_limit(size_val);
    if (with_directed)
      add_directed();
    px = 0;
    pz = 0;
    pw = 1;
    ph = 1;
    if (gen_size > 0) begin
      span = (gen_size < 6) ? gen_size : 6;
      pw = $urandom_range(1, span);
      ph = $urandom_range(1, span);
      case ($urandom_range(0, 2))
        0:       px = 0;
        1:       px = gen_size - pw;
        default: px = $urandom_range(0, gen_size - pw);
      endcase
      case ($urandom_range(0, 2))
        0:       pz = 0;
        1:       pz = gen_size - ph;
        default: pz = $urandom_range(0, gen_size - ph);
      endcase
      for (i = 0; i < pw; i++)
        for (j = 0; j < ph; j++)
          add_load(px + i, pz + j);
    end
    for (i = 0; i < n_random; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        add_random_query(px, pz, pw, ph);
      else if (r < 82)
        add_load(px + $urandom_range(0, pw - 1), pz + $urandom_range(0, ph - 1));
      else
        add_item(CMD_LOAD, pick_coord(), pick_coord(), pick_height());
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_LOAD;
    in_ch.coord_x       = '0;
    in_ch.coord_z       = '0;
    in_ch.height_value  = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.grid_size    = '0;
    out_ch.ready        = 1'b0;
    gen_size            = CFG_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(2, 60, 1'b1);
    run_phase(128, 130, 1'b0);
    run_phase($urandom_range(3, 126), 110, 1'b0);
    run_phase(255, 110, 1'b0);
    run_phase(0, 40, 1'b0);
    run_phase(1, 60, 1'b0);
    run_phase(127, 110, 1'b0);
    run_phase(2, 50, 1'b0);
    wait_drained();

    if (expected_heights.size() != 0)
      err_count++;
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bhgs_pkg.sv
rtl/core/bhgs_ifs.sv
rtl/core/bhgs_ram.sv
rtl/core/bhgs_store.sv
rtl/core/bhgs_interp.sv
rtl/core/bilinear_height_grid_sampler.sv
rtl/core/bhgs_checker.sv
verif/bilinear_height_grid_sampler_tb.sv
